[design/adc_offset_calibrate_and_scale_macros.svh]
// assertion helpers shared by the divider and the top-level module
// each macro expects clk and rst_n in scope
`ifndef ADC_OFFSET_CALIBRATE_AND_SCALE_MACROS_SVH
`define ADC_OFFSET_CALIBRATE_AND_SCALE_MACROS_SVH

// same-cycle implication
`define ADCS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adcs assertion failed");

// next-cycle implication
`define ADCS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adcs assertion failed");

`endif

[design/adcs_pkg.sv]
`default_nettype none

package adcs_pkg;

    // converter code format
    localparam int CODE_BITS = 12;
    localparam logic [CODE_BITS-1:0] ZERO_CODE = 12'd2048;
    localparam logic [CODE_BITS-1:0] CODE_MAX  = 12'hFFF;

    localparam int NUM_PHASES = 3;

    // datapath widths
    localparam int GAIN_W = 16;
    localparam int CNT_W  = 16;
    localparam int SUM_W  = 28;
    localparam int CUR_W  = 29;
    localparam int VB_W   = 28;
    localparam int DIFF_W = CODE_BITS + 1;
    localparam int PROD_W = DIFF_W + GAIN_W + 1;
    localparam int STEP_W = $clog2(CODE_BITS);

    // register map
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_CALIB_SAMPLES = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CURRENT_GAIN  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_VBUS_GAIN     = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_PHASE_NEGATE  = 2'd3;

    // register reset values
    localparam logic [CNT_W-1:0]  RST_CALIB_SAMPLES = 16'd256;
    localparam logic [GAIN_W-1:0] RST_CURRENT_GAIN  = 16'd655;
    localparam logic [GAIN_W-1:0] RST_VBUS_GAIN     = 16'd0;

    // request kinds
    localparam logic REQ_CONVERT = 1'b0;
    localparam logic REQ_CALIB   = 1'b1;

    // divider status back to the sequencer
    typedef struct packed {
        logic                 done;
        logic [CODE_BITS-1:0] quot;
    } div_stat_t;

endpackage

`default_nettype wire

[design/adcs_mul.sv]
`default_nettype none

module adcs_mul (
    input  wire logic                                clk,
    input  wire logic signed [adcs_pkg::DIFF_W-1:0]  a,
    input  wire logic        [adcs_pkg::GAIN_W-1:0]  b,
    output logic signed      [adcs_pkg::PROD_W-1:0]  p
);

    logic signed [adcs_pkg::PROD_W-1:0] p_reg;
    logic signed [adcs_pkg::PROD_W-1:0] p_next;

    // signed operand times unsigned gain
    assign p_next = adcs_pkg::PROD_W'(a * $signed({1'b0, b}));

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

[design/adcs_div.sv]
`default_nettype none

module adcs_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [adcs_pkg::SUM_W-1:0]    dividend,
    input  wire logic [adcs_pkg::CNT_W-1:0]    divisor,
    output adcs_pkg::div_stat_t                stat
);

    `include "adc_offset_calibrate_and_scale_macros.svh"

    localparam logic [adcs_pkg::STEP_W-1:0] LAST_STEP =
        adcs_pkg::STEP_W'(adcs_pkg::CODE_BITS - 1);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [adcs_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [adcs_pkg::CNT_W-1:0]      rem_reg, rem_next;
    logic [adcs_pkg::CODE_BITS-1:0]  work_reg, work_next;

    logic [adcs_pkg::CNT_W:0]        trial;
    logic                            ge;
    logic                            sat;

    // quotient overflows the code range exactly when the upper bits reach the divisor
    assign sat   = dividend[adcs_pkg::SUM_W-1:adcs_pkg::CODE_BITS] >= divisor;
    assign trial = {rem_reg, work_reg[adcs_pkg::CODE_BITS-1]};
    assign ge    = trial >= {1'b0, divisor};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        work_next = work_reg;
        if (start)
        begin
            if (sat)
            begin
                work_next = adcs_pkg::CODE_MAX;
                done_next = 1'b1;
            end
            else
            begin
                rem_next  = dividend[adcs_pkg::SUM_W-1:adcs_pkg::CODE_BITS];
                work_next = dividend[adcs_pkg::CODE_BITS-1:0];
                step_next = '0;
                busy_next = 1'b1;
            end
        end
        else if (busy_reg)
        begin
            // restoring step: one quotient bit per cycle
            rem_next  = ge ? adcs_pkg::CNT_W'(trial - {1'b0, divisor})
                           : trial[adcs_pkg::CNT_W-1:0];
            work_next = {work_reg[adcs_pkg::CODE_BITS-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
    end

    assign stat.done = done_reg;
    assign stat.quot = work_reg;

    `ADCS_ASSERT_NEXT(a_start_acts, start && !busy_reg, busy_reg || done_reg)
    `ADCS_ASSERT_NEXT(a_last_step_done, busy_reg && step_reg == LAST_STEP && !start,
                      done_reg && !busy_reg)
    `ADCS_ASSERT_IMPL(a_no_restart, busy_reg, !start)

endmodule

`default_nettype wire

[design/adc_offset_calibrate_and_scale.sv]
// sequence: a conversion transaction passes through the four multiplier slots, the post
// state and the output register; a calibration transaction that completes the averaging
// also runs one divide per phase, shorter when a quotient saturates and the divider skips
// its restoring steps; flow: one transaction at a time, set by the shared multiplier (four
// products) and the 12-step shared divider (three phases); a new one is taken only in idle
// reset: asynchronous active low; offsets to the zero code, sums and count cleared,
// registers to their defaults
`default_nettype none

module adc_offset_calibrate_and_scale (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // input stream
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [47:0]                        s_tdata,   // code_u, code_v, code_w, code_vbus
    input  wire logic [0:0]                         s_tuser,   // req_type
    // output stream
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [119:0]                            m_tdata,   // current_u, current_v,
                                                               // current_w, bus_volts, pad
    output logic [0:0]                              m_tuser,   // calib_done
    // configuration write port
    input  wire logic                               cfg_we,
    input  wire logic [adcs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [15:0]                        cfg_wdata
);

    `include "adc_offset_calibrate_and_scale_macros.svh"

    localparam int CB = adcs_pkg::CODE_BITS;
    localparam int NP = adcs_pkg::NUM_PHASES;

    // sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;   // four products through the shared multiplier
    localparam logic [2:0] S_POST = 3'd2;   // last product lands, calibration count decision
    localparam logic [2:0] S_DIVS = 3'd3;   // launch divide for one phase
    localparam logic [2:0] S_DIVW = 3'd4;   // wait for the quotient, commit offset
    localparam logic [2:0] S_FIN  = 3'd5;   // hand result to the output register

    localparam logic [1:0] IDX_VBUS = 2'd3;
    localparam logic [1:0] IDX_LAST_PHASE = 2'(NP - 1);

    // configuration registers
    logic [adcs_pkg::CNT_W-1:0]   calib_samples_reg;
    logic [adcs_pkg::GAIN_W-1:0]  current_gain_reg;
    logic [adcs_pkg::GAIN_W-1:0]  vbus_gain_reg;
    logic [NP-1:0]                phase_negate_reg;

    // sequencer
    logic [2:0]  state_reg, state_next;
    logic [1:0]  idx_reg, idx_next;
    logic        mul_vld_reg;
    logic [1:0]  mul_idx_reg;

    // calibration state
    logic [CB-1:0]                offset_reg [NP];
    logic [adcs_pkg::SUM_W-1:0]   sum_reg    [NP];
    logic [adcs_pkg::CNT_W-1:0]   count_reg;

    // captured transaction
    logic           type_reg;
    logic [CB-1:0]  code_reg [NP];
    logic [CB-1:0]  vbus_code_reg;

    // results under construction
    logic signed [adcs_pkg::CUR_W-1:0]  cur_reg [NP];
    logic [adcs_pkg::VB_W-1:0]          vb_reg;
    logic                               done_flag_reg;

    // output register
    logic                               out_valid_reg;
    logic [119:0]                       out_data_reg;
    logic                               out_done_reg;

    // shared units
    logic signed [adcs_pkg::DIFF_W-1:0]  mul_a;
    logic        [adcs_pkg::GAIN_W-1:0]  mul_b;
    logic signed [adcs_pkg::PROD_W-1:0]  mul_p;
    logic signed [adcs_pkg::DIFF_W-1:0]  diff;
    logic                                div_start;
    logic [adcs_pkg::CNT_W-1:0]          n_eff;
    adcs_pkg::div_stat_t                 div_stat;

    logic                                accept;
    logic                                out_load;
    logic [adcs_pkg::CNT_W-1:0]          cnt_inc;
    logic                                avg_done;
    logic [1:0]                          phase_idx;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = state_reg == S_IDLE;
    assign out_load = state_reg == S_FIN && (!out_valid_reg || m_tready);

    // a sample count of zero behaves as one
    assign n_eff = (calib_samples_reg == '0) ? adcs_pkg::CNT_W'(1) : calib_samples_reg;

    // count wraps after 65536 samples, which also forces the averaging
    assign cnt_inc  = count_reg + 1'b1;
    assign avg_done = (cnt_inc >= n_eff) || (cnt_inc == '0);

    // phase selection guarded so the bus index never reaches the 3-entry arrays
    assign phase_idx = (idx_reg == IDX_VBUS) ? 2'd0 : idx_reg;

    // multiplier operands: offset-corrected phase code (sign folded in) or bus code
    assign diff = $signed({1'b0, code_reg[phase_idx]}) - $signed({1'b0, offset_reg[phase_idx]});

    always_comb
    begin
        if (idx_reg == IDX_VBUS)
        begin
            mul_a = $signed({1'b0, vbus_code_reg});
            mul_b = vbus_gain_reg;
        end
        else
        begin
            mul_a = phase_negate_reg[phase_idx] ? -diff : diff;
            mul_b = current_gain_reg;
        end
    end

    adcs_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign div_start = state_reg == S_DIVS;

    adcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[phase_idx]),
        .divisor  (n_eff),
        .stat     (div_stat)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL;
                    idx_next   = 2'd0;
                end
            end
            S_MUL:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_VBUS)
                begin
                    state_next = S_POST;
                end
            end
            S_POST:
            begin
                idx_next = 2'd0;
                if (type_reg == adcs_pkg::REQ_CALIB && avg_done)
                begin
                    state_next = S_DIVS;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_DIVS:
            begin
                state_next = S_DIVW;
            end
            S_DIVW:
            begin
                if (div_stat.done)
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = (idx_reg == IDX_LAST_PHASE) ? S_FIN : S_DIVS;
                end
            end
            S_FIN:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and calibration state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            idx_reg           <= 2'd0;
            mul_vld_reg       <= 1'b0;
            mul_idx_reg       <= 2'd0;
            calib_samples_reg <= adcs_pkg::RST_CALIB_SAMPLES;
            current_gain_reg  <= adcs_pkg::RST_CURRENT_GAIN;
            vbus_gain_reg     <= adcs_pkg::RST_VBUS_GAIN;
            phase_negate_reg  <= '0;
            count_reg         <= '0;
            out_valid_reg     <= 1'b0;
            for (int i = 0; i < NP; i++)
            begin
                offset_reg[i] <= adcs_pkg::ZERO_CODE;
                sum_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            mul_vld_reg <= state_reg == S_MUL;
            mul_idx_reg <= idx_reg;

            if (cfg_we)
            begin
                case (cfg_addr)
                    adcs_pkg::REG_CALIB_SAMPLES: calib_samples_reg <= cfg_wdata;
                    adcs_pkg::REG_CURRENT_GAIN:  current_gain_reg  <= cfg_wdata;
                    adcs_pkg::REG_VBUS_GAIN:     vbus_gain_reg     <= cfg_wdata;
                    adcs_pkg::REG_PHASE_NEGATE:  phase_negate_reg  <= cfg_wdata[NP-1:0];
                    default: ;
                endcase
            end

            // calibration samples accumulate one phase per multiplier slot
            if (state_reg == S_MUL && idx_reg != IDX_VBUS && type_reg == adcs_pkg::REQ_CALIB)
            begin
                sum_reg[phase_idx] <= sum_reg[phase_idx] +
                                      adcs_pkg::SUM_W'(code_reg[phase_idx]);
            end

            if (state_reg == S_POST && type_reg == adcs_pkg::REQ_CALIB)
            begin
                count_reg <= avg_done ? '0 : cnt_inc;
            end

            // commit the new offset and restart that phase's sum
            if (state_reg == S_DIVW && div_stat.done)
            begin
                offset_reg[phase_idx] <= div_stat.quot;
                sum_reg[phase_idx]    <= '0;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            type_reg      <= s_tuser[0];
            code_reg[0]   <= s_tdata[CB-1:0];
            code_reg[1]   <= s_tdata[2*CB-1:CB];
            code_reg[2]   <= s_tdata[3*CB-1:2*CB];
            vbus_code_reg <= s_tdata[4*CB-1:3*CB];
            done_flag_reg <= 1'b0;
        end

        // products land in the cycle after issue; calibration items report zero currents
        if (mul_vld_reg)
        begin
            if (mul_idx_reg == IDX_VBUS)
            begin
                vb_reg <= mul_p[adcs_pkg::VB_W-1:0];
            end
            else if (type_reg == adcs_pkg::REQ_CALIB)
            begin
                cur_reg[mul_idx_reg] <= '0;
            end
            else
            begin
                cur_reg[mul_idx_reg] <= mul_p[adcs_pkg::CUR_W-1:0];
            end
        end

        if (state_reg == S_POST)
        begin
            done_flag_reg <= type_reg == adcs_pkg::REQ_CALIB && avg_done;
        end

        if (out_load)
        begin
            out_data_reg <= {5'd0, vb_reg, cur_reg[2], cur_reg[1], cur_reg[0]};
            out_done_reg <= done_flag_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_done_reg;

    `ADCS_ASSERT_IMPL(a_load_when_free, out_load, !out_valid_reg || m_tready)
    `ADCS_ASSERT_NEXT(a_accept_starts, accept, state_reg == S_MUL && idx_reg == 2'd0)
    `ADCS_ASSERT_IMPL(a_done_zero_currents, m_tvalid && m_tuser[0],
                      m_tdata[3*adcs_pkg::CUR_W-1:0] == '0)
    `ADCS_ASSERT_IMPL(a_div_only_in_wait, div_stat.done, state_reg == S_DIVW)

endmodule

`default_nettype wire

[sim/tb_adc_offset_calibrate_and_scale.sv]
`timescale 1ns / 1ps

module tb_adc_offset_calibrate_and_scale;

    // cycles without any transaction or register write before the run is declared hung
    localparam int STALL_LIMIT  = 3000;
    // settle time after the last result, above the longest calibration latency
    localparam int DRAIN_CYCLES = 60;
    localparam int NUM_RANDOM_PHASES = 12;
    localparam int SETS_PER_PHASE    = 46;

    // one input transaction, packed so that {req, tdata} lines up with {s_tuser, s_tdata}
    typedef struct packed {
        logic                           req;
        logic [adcs_pkg::CODE_BITS-1:0] vbus;
        logic [adcs_pkg::CODE_BITS-1:0] w;
        logic [adcs_pkg::CODE_BITS-1:0] v;
        logic [adcs_pkg::CODE_BITS-1:0] u;
    } sample_set_t;

    // one expected output transaction
    typedef struct packed {
        logic [2:0][adcs_pkg::CUR_W-1:0] amps;   // phase u at index 0
        logic [adcs_pkg::VB_W-1:0]       volts;
        logic                            done;
    } reading_t;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [47:0]                     s_tdata   = '0;   // code_u, code_v, code_w, code_vbus
    logic [0:0]                      s_tuser   = '0;   // req_type
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [119:0]                    m_tdata;          // current_u, current_v, current_w,
                                                       // bus_volts, pad
    logic [0:0]                      m_tuser;          // calib_done
    logic                            cfg_we    = 1'b0;
    logic [adcs_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [15:0]                     cfg_wdata = '0;

    // register copy, follows every write seen on the config port
    logic [15:0] reg_calib_samples;
    logic [15:0] reg_current_gain;
    logic [15:0] reg_vbus_gain;
    logic [2:0]  reg_phase_negate;

    // calibration state of the predictor
    logic [adcs_pkg::CODE_BITS-1:0] phase_offset [3];
    logic [31:0]                    calib_acc [3];
    logic [15:0]                    calib_seen;

    sample_set_t pending_sets[$];
    reading_t    expected_readings[$];

    // idle percentages per side, changed only between phases
    int send_idle_pct = 33;
    int recv_idle_pct = 74;
    int error_count   = 0;
    int stall_cycles  = 0;

    always #5 clk = ~clk;

    adc_offset_calibrate_and_scale i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // expected result of one sample set; advances the calibration state
    function automatic reading_t predict_reading(logic req, logic [47:0] data);
        reading_t                       r;
        logic [adcs_pkg::CODE_BITS-1:0] code [3];
        longint                         c;
        longint                         o;
        longint                         g;
        longint                         amps;
        longint unsigned                divisor;
        longint unsigned                quot;
        code[0] = data[11:0];
        code[1] = data[23:12];
        code[2] = data[35:24];
        r = '0;
        // bus voltage is scaled on both kinds of transaction
        r.volts = data[47:36] * reg_vbus_gain;
        if (req == adcs_pkg::REQ_CALIB)
        begin
            for (int i = 0; i < adcs_pkg::NUM_PHASES; i++)
                calib_acc[i] = calib_acc[i] + code[i];
            calib_seen = calib_seen + 16'd1;
            // a count of zero averages over one sample
            divisor = (reg_calib_samples == 16'd0) ? 1 : reg_calib_samples;
            // the count may have been lowered below what is already gathered,
            // and a wrapped count also closes the run
            if (calib_seen >= divisor || calib_seen == 16'd0)
            begin
                for (int i = 0; i < adcs_pkg::NUM_PHASES; i++)
                begin
                    quot = calib_acc[i] / divisor;
                    phase_offset[i] = (quot > adcs_pkg::CODE_MAX) ? adcs_pkg::CODE_MAX
                                                                   : quot[adcs_pkg::CODE_BITS-1:0];
                    calib_acc[i] = '0;
                end
                calib_seen = '0;
                r.done = 1'b1;
            end
        end
        else
        begin
            g = reg_current_gain;
            for (int i = 0; i < adcs_pkg::NUM_PHASES; i++)
            begin
                c = code[i];
                o = phase_offset[i];
                amps = (c - o) * g;
                if (reg_phase_negate[i])
                    amps = -amps;
                r.amps[i] = amps[adcs_pkg::CUR_W-1:0];
            end
        end
        return r;
    endfunction

    function automatic void compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    // compare one output transaction against the oldest expected reading
    function automatic void check_reading(logic [119:0] data, logic done);
        reading_t want;
        if (expected_readings.size() == 0)
        begin
            $display("%0t: output transaction with nothing expected, data %h", $time, data);
            error_count++;
            return;
        end
        want = expected_readings.pop_front();
        compare_field("current_u", $signed(want.amps[0]),
                      $signed(data[0*adcs_pkg::CUR_W +: adcs_pkg::CUR_W]));
        compare_field("current_v", $signed(want.amps[1]),
                      $signed(data[1*adcs_pkg::CUR_W +: adcs_pkg::CUR_W]));
        compare_field("current_w", $signed(want.amps[2]),
                      $signed(data[2*adcs_pkg::CUR_W +: adcs_pkg::CUR_W]));
        compare_field("bus_volts", want.volts, data[3*adcs_pkg::CUR_W +: adcs_pkg::VB_W]);
        compare_field("calib_done", want.done, done);
    endfunction

    // register copy, written on the same edge as the block's registers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reg_calib_samples <= adcs_pkg::RST_CALIB_SAMPLES;
            reg_current_gain  <= adcs_pkg::RST_CURRENT_GAIN;
            reg_vbus_gain     <= adcs_pkg::RST_VBUS_GAIN;
            reg_phase_negate  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                adcs_pkg::REG_CALIB_SAMPLES: reg_calib_samples <= cfg_wdata;
                adcs_pkg::REG_CURRENT_GAIN:  reg_current_gain  <= cfg_wdata;
                adcs_pkg::REG_VBUS_GAIN:     reg_vbus_gain     <= cfg_wdata;
                adcs_pkg::REG_PHASE_NEGATE:  reg_phase_negate  <= cfg_wdata[2:0];
                default:                     ;
            endcase
        end
    end

    // input driver: predicts each accepted transaction, then offers the next set
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            for (int i = 0; i < adcs_pkg::NUM_PHASES; i++)
            begin
                phase_offset[i] = adcs_pkg::ZERO_CODE;
                calib_acc[i]    = '0;
            end
            calib_seen = '0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_readings.push_back(predict_reading(s_tuser[0], s_tdata));
            // the bus is free when nothing is offered or the offer was just taken
            if (!s_tvalid || s_tready)
            begin
                if (pending_sets.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    {s_tuser, s_tdata} <= pending_sets.pop_front();
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output monitor with random backpressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
                check_reading(m_tdata, m_tuser[0]);
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // hang detection: any transaction or register write restarts the count
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic void push_set(logic req, logic [adcs_pkg::CODE_BITS-1:0] u,
                                     logic [adcs_pkg::CODE_BITS-1:0] v,
                                     logic [adcs_pkg::CODE_BITS-1:0] w,
                                     logic [adcs_pkg::CODE_BITS-1:0] vbus);
        pending_sets.push_back({req, vbus, w, v, u});
    endfunction

    // wait until every set went in and every reading came back;
    // sampled on the falling edge so the driver and monitor updates have settled
    task automatic drain();
        while (pending_sets.size() != 0 || s_tvalid || expected_readings.size() != 0)
            @(negedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(logic [adcs_pkg::CFG_ADDR_W-1:0] addr, logic [15:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // gains favor the two ends of the range
    function automatic logic [15:0] pick_gain();
        int pick;
        pick = $urandom_range(9);
        if (pick < 2)
            return 16'd0;
        if (pick < 4)
            return 16'hFFFF;
        return 16'($urandom_range(16'hFFFF));
    endfunction

    function automatic logic [adcs_pkg::CODE_BITS-1:0] rand_code();
        return adcs_pkg::CODE_BITS'($urandom_range(4095));
    endfunction

    // mostly calibration bursts around a drifting zero followed by conversions,
    // with some fully random sets that break the burst alignment
    task automatic queue_phase(int n_sets, int burst_len);
        int                             queued = 0;
        int                             convs;
        logic [adcs_pkg::CODE_BITS-1:0] center [3];
        while (queued < n_sets)
        begin
            if ($urandom_range(9) < 7)
            begin
                for (int i = 0; i < adcs_pkg::NUM_PHASES; i++)
                    center[i] = adcs_pkg::CODE_BITS'($urandom_range(2300, 1800));
                repeat (burst_len)
                    push_set(adcs_pkg::REQ_CALIB,
                             center[0] + adcs_pkg::CODE_BITS'($urandom_range(15)),
                             center[1] + adcs_pkg::CODE_BITS'($urandom_range(15)),
                             center[2] + adcs_pkg::CODE_BITS'($urandom_range(15)),
                             rand_code());
                convs = $urandom_range(4, 1);
                repeat (convs)
                    push_set(adcs_pkg::REQ_CONVERT, rand_code(), rand_code(),
                             rand_code(), rand_code());
                queued += burst_len + convs;
            end
            else
            begin
                push_set(1'($urandom_range(1)), rand_code(), rand_code(),
                         rand_code(), rand_code());
                queued++;
            end
        end
    endtask

    initial
    begin
        int pick;
        int samples;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: code extremes and alternating bit patterns
        push_set(adcs_pkg::REQ_CONVERT, 12'd0, 12'd0, 12'd0, 12'd0);
        push_set(adcs_pkg::REQ_CONVERT, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        push_set(adcs_pkg::REQ_CONVERT, 12'd2048, 12'd2047, 12'd2049, 12'hFFF);
        push_set(adcs_pkg::REQ_CONVERT, 12'hAAA, 12'h555, 12'hAAA, 12'h555);
        // partial calibration run, then a conversion that must still use the old offsets
        for (int i = 0; i < 5; i++)
            push_set(adcs_pkg::REQ_CALIB, 12'hFFF, 12'hFFF, 12'hFFF, adcs_pkg::CODE_BITS'(i));
        push_set(adcs_pkg::REQ_CONVERT, 12'd100, 12'd3000, 12'd2048, 12'd2000);
        drain();

        // count lowered below what is gathered: next calibration closes and saturates
        write_reg(adcs_pkg::REG_CALIB_SAMPLES, 16'd3);
        write_reg(adcs_pkg::REG_CURRENT_GAIN, 16'hFFFF);
        write_reg(adcs_pkg::REG_VBUS_GAIN, 16'hFFFF);
        write_reg(adcs_pkg::REG_PHASE_NEGATE, 16'd7);
        push_set(adcs_pkg::REQ_CALIB, 12'hFFF, 12'hFFF, 12'hFFF, 12'd0);
        push_set(adcs_pkg::REQ_CONVERT, 12'd0, 12'd0, 12'd0, 12'hFFF);
        push_set(adcs_pkg::REQ_CONVERT, 12'hFFF, 12'd2048, 12'd1, 12'd0);
        drain();

        // zero sample count averages over a single sample
        write_reg(adcs_pkg::REG_CALIB_SAMPLES, 16'd0);
        write_reg(adcs_pkg::REG_PHASE_NEGATE, 16'd5);
        write_reg(adcs_pkg::REG_CURRENT_GAIN, 16'd0);
        push_set(adcs_pkg::REQ_CALIB, 12'd0, 12'd1, 12'd2, 12'd7);
        push_set(adcs_pkg::REQ_CONVERT, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
        drain();

        write_reg(adcs_pkg::REG_CURRENT_GAIN, 16'd1);
        write_reg(adcs_pkg::REG_CALIB_SAMPLES, 16'd2);
        push_set(adcs_pkg::REQ_CALIB, 12'hFFF, 12'hFFE, 12'd0, 12'd3);
        push_set(adcs_pkg::REQ_CALIB, 12'hFFF, 12'hFFF, 12'd1, 12'd4);
        push_set(adcs_pkg::REQ_CONVERT, 12'd0, 12'hFFF, 12'hFFF, 12'hFFF);
        push_set(adcs_pkg::REQ_CONVERT, 12'd0, 12'd0, 12'd0, 12'd0);
        drain();

        // largest count, left open so the first random phase lowers it mid-run
        write_reg(adcs_pkg::REG_CALIB_SAMPLES, 16'hFFFF);
        push_set(adcs_pkg::REQ_CALIB, 12'd2100, 12'd1990, 12'd2050, 12'd9);
        push_set(adcs_pkg::REQ_CALIB, 12'd2101, 12'd1991, 12'd2051, 12'd9);
        drain();

        // random phases: receiver idles more, then sender idles more, then no idling
        for (int p = 0; p < NUM_RANDOM_PHASES; p++)
        begin
            send_idle_pct = (p < 4) ? 33 : (p < 8) ? 74 : 0;
            recv_idle_pct = (p < 4) ? 74 : (p < 8) ? 33 : 0;
            pick = $urandom_range(9);
            if (p == 0)
                samples = $urandom_range(8, 1);
            else if (pick == 0)
                samples = 0;
            else if (pick == 1)
                samples = 16'hFFFF;
            else
                samples = $urandom_range(8, 1);
            write_reg(adcs_pkg::REG_CALIB_SAMPLES, 16'(samples));
            write_reg(adcs_pkg::REG_CURRENT_GAIN, pick_gain());
            write_reg(adcs_pkg::REG_VBUS_GAIN, pick_gain());
            write_reg(adcs_pkg::REG_PHASE_NEGATE, 16'($urandom_range(7)));
            queue_phase(SETS_PER_PHASE, (samples == 0) ? 1 : (samples > 12) ? 12 : samples);
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
